[rtl/core/bfpa_pkg.sv]
`timescale 1ns / 1ps
// Package for the best-fit page allocator: sizes, status codes, FSM states
// and the controller/datapath command and status structs. No dependencies.
package bfpa_pkg;
  localparam int HEAP_PAGES = 1024;
  localparam int MAX_BLOCKS = 1024;
  localparam int PAGE_SHIFT = 12;
  localparam int PW = $clog2(HEAP_PAGES);
  localparam int BW = $clog2(MAX_BLOCKS);
  localparam int CW = BW + 1;
  localparam int NW = PW + 1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NO_FIT = 2'd1, ST_TABLE_FULL = 2'd2, ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_MARK, S_FRD, S_FCMP, S_CLEAR, S_SHRD, S_SHWR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic init_step;
    logic start_alloc;
    logic start_free;
    logic scan_step;
    logic mark_step;
    logic append;
    logic frd;
    logic fcmp;
    logic clear_step;
    logic shrd;
    logic shwr;
    logic set_res;
    status_e res_status;
    logic res_addr_ok;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic scan_done;
    logic found;
    logic full;
    logic mark_done;
    logic search_end;
    logic hit;
    logic clear_done;
    logic shift_done;
  } sts_t;
endpackage

[rtl/core/best_fit_page_allocator_unit.sv]
`timescale 1ns / 1ps
// Best-fit page allocator top level: stream ports, heap_base register, ctrl+datapath.
// Reset: async active low; heap_base 0, table empty, then the page map is cleared.
// Allocate: page map scan, decide, then marking if a run fits and the table has room.
// Free: table search by address; on a hit, the block's pages are cleared and
// later entries shifted down. One item at a time; result held until taken.
module best_fit_page_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] size_bytes, [63:32] address
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] result_address, [33:32] status, rest 0
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  logic [31:0] heap_base_q;
  bfpa_pkg::cmd_t cmd;
  bfpa_pkg::sts_t sts;
  logic busy, in_fire, out_fire, ovalid_q;
  logic [31:0] res_addr;
  logic [1:0] res_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) heap_base_q <= '0;
    else if (cfg_we_i) heap_base_q <= cfg_wdata_i;
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd.set_res) ovalid_q <= 1'b1;
    else if (out_fire) ovalid_q <= 1'b0;
  end

  bfpa_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_fire_i(in_fire), .op_free_i(s_axis_tuser),
    .out_free_i(out_fire), .sts_i(sts), .cmd_o(cmd), .busy_o(busy));

  bfpa_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .size_i(s_axis_tdata[31:0]),
    .addr_i(s_axis_tdata[63:32]), .heap_base_i(heap_base_q), .sts_o(sts),
    .res_addr_o(res_addr), .res_status_o(res_status));

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {6'd0, res_status, res_addr};
endmodule

[rtl/core/bfpa_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module bfpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/core/bfpa_ctrl.sv]
`timescale 1ns / 1ps
// Allocator controller FSM: sequences scan, mark, search, clear, compaction.
// Depends on bfpa_pkg.
module bfpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic           op_free_i,
  input  logic           out_free_i,
  input  bfpa_pkg::sts_t sts_i,
  output bfpa_pkg::cmd_t cmd_o,
  output logic           busy_o
);
  bfpa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bfpa_pkg::S_INIT;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfpa_pkg::S_INIT: if (sts_i.init_done) state_d = bfpa_pkg::S_IDLE;
      bfpa_pkg::S_IDLE:
        if (in_fire_i) state_d = op_free_i ? bfpa_pkg::S_FRD : bfpa_pkg::S_SCAN;
      bfpa_pkg::S_SCAN: if (sts_i.scan_done) state_d = bfpa_pkg::S_DECIDE;
      bfpa_pkg::S_DECIDE:
        if (!sts_i.found || sts_i.full) state_d = bfpa_pkg::S_DONE;
        else state_d = bfpa_pkg::S_MARK;
      bfpa_pkg::S_MARK: if (sts_i.mark_done) state_d = bfpa_pkg::S_DONE;
      bfpa_pkg::S_FRD:
        if (sts_i.search_end) state_d = bfpa_pkg::S_DONE;
        else state_d = bfpa_pkg::S_FCMP;
      bfpa_pkg::S_FCMP: state_d = sts_i.hit ? bfpa_pkg::S_CLEAR : bfpa_pkg::S_FRD;
      bfpa_pkg::S_CLEAR: if (sts_i.clear_done) state_d = bfpa_pkg::S_SHRD;
      bfpa_pkg::S_SHRD:
        if (sts_i.shift_done) state_d = bfpa_pkg::S_DONE;
        else state_d = bfpa_pkg::S_SHWR;
      bfpa_pkg::S_SHWR: state_d = bfpa_pkg::S_SHRD;
      bfpa_pkg::S_DONE: if (out_free_i) state_d = bfpa_pkg::S_IDLE;
      default: state_d = bfpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = bfpa_pkg::ST_OK;
    case (state_q)
      bfpa_pkg::S_INIT: cmd_o.init_step = !sts_i.init_done;
      bfpa_pkg::S_IDLE: begin
        cmd_o.start_alloc = in_fire_i && !op_free_i;
        cmd_o.start_free = in_fire_i && op_free_i;
      end
      bfpa_pkg::S_SCAN: cmd_o.scan_step = 1'b1;
      bfpa_pkg::S_DECIDE: begin
        if (!sts_i.found) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = bfpa_pkg::ST_NO_FIT;
        end else if (sts_i.full) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = bfpa_pkg::ST_TABLE_FULL;
        end else begin
          cmd_o.append = 1'b1;
        end
      end
      bfpa_pkg::S_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (sts_i.mark_done) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_addr_ok = 1'b1;
        end
      end
      bfpa_pkg::S_FRD: begin
        cmd_o.frd = 1'b1;
        if (sts_i.search_end) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = bfpa_pkg::ST_NOT_FOUND;
        end
      end
      bfpa_pkg::S_FCMP: cmd_o.fcmp = 1'b1;
      bfpa_pkg::S_CLEAR: cmd_o.clear_step = 1'b1;
      bfpa_pkg::S_SHRD: begin
        cmd_o.shrd = 1'b1;
        cmd_o.set_res = sts_i.shift_done;
      end
      bfpa_pkg::S_SHWR: cmd_o.shwr = 1'b1;
      default: ;
    endcase
  end

  assign busy_o = (state_q != bfpa_pkg::S_IDLE);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfpa_pkg::S_DONE && out_free_i) |=> state_q == bfpa_pkg::S_IDLE)
    else $error("done did not return to idle");
  a_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfpa_pkg::S_DECIDE |=> (state_q == bfpa_pkg::S_MARK ||
      state_q == bfpa_pkg::S_DONE))
    else $error("bad decide exit");
  a_shwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfpa_pkg::S_SHWR |-> $past(state_q) == bfpa_pkg::S_SHRD)
    else $error("shift write without read");
endmodule

[rtl/core/bfpa_dp.sv]
`timescale 1ns / 1ps
// Allocator datapath: page bitmap, run scan, block table RAMs, result register.
// Depends on bfpa_pkg and bfpa_ram.
module bfpa_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bfpa_pkg::cmd_t cmd_i,
  input  logic [31:0]    size_i,
  input  logic [31:0]    addr_i,
  input  logic [31:0]    heap_base_i,
  output bfpa_pkg::sts_t sts_o,
  output logic [31:0]    res_addr_o,
  output logic [1:0]     res_status_o
);
  localparam int PW = bfpa_pkg::PW;
  localparam int BW = bfpa_pkg::BW;
  localparam int CW = bfpa_pkg::CW;
  localparam int NW = bfpa_pkg::NW;

  logic [NW-1:0] idx_q, run_q, best_len_q, ini_q;
  logic [PW-1:0] run_start_q, best_start_q, cur_start_q;
  logic found_q;
  logic [NW:0] need_q;
  logic [CW-1:0] count_q, bidx_q;
  logic [NW-1:0] cur_cnt_q, k_q;
  logic [31:0] addr_q, res_addr_q;
  logic [1:0] res_status_q;

  logic [PW-1:0] rd_start;
  logic [NW-1:0] rd_cnt;
  logic tbl_we;
  logic [BW-1:0] tbl_wa, tbl_ra;
  logic [PW-1:0] tbl_ws;
  logic [NW-1:0] tbl_wc;

  logic used_we, used_wd, used_rd;
  logic [PW-1:0] used_wa, used_ra;

  bfpa_ram #(.Width(PW), .Depth(bfpa_pkg::MAX_BLOCKS)) u_start (
    .clk_i(clk_i), .we_i(tbl_we), .waddr_i(tbl_wa), .wdata_i(tbl_ws),
    .raddr_i(tbl_ra), .rdata_o(rd_start));
  bfpa_ram #(.Width(NW), .Depth(bfpa_pkg::MAX_BLOCKS)) u_cnt (
    .clk_i(clk_i), .we_i(tbl_we), .waddr_i(tbl_wa), .wdata_i(tbl_wc),
    .raddr_i(tbl_ra), .rdata_o(rd_cnt));
  bfpa_ram #(.Width(1), .Depth(bfpa_pkg::HEAP_PAGES)) u_used (
    .clk_i(clk_i), .we_i(used_we), .waddr_i(used_wa), .wdata_i(used_wd),
    .raddr_i(used_ra), .rdata_o(used_rd));

  // size in pages, rounded up; saturated to one beyond heap size when loaded into need_q
  logic [32-bfpa_pkg::PAGE_SHIFT:0] need_full;
  assign need_full = {1'b0, size_i[31:bfpa_pkg::PAGE_SHIFT]} +
                     (33-bfpa_pkg::PAGE_SHIFT)'(|size_i[bfpa_pkg::PAGE_SHIFT-1:0]);

  // scan reads page idx, evaluates page idx-1 from the registered read data
  logic at_end, cur_used, proc;
  logic [NW-1:0] pos;
  logic [NW-1:0] run_len;
  logic close_ok;
  assign pos = idx_q - NW'(1);
  assign proc = (idx_q != '0);
  assign at_end = (idx_q == NW'(bfpa_pkg::HEAP_PAGES + 1));
  assign cur_used = (pos == NW'(bfpa_pkg::HEAP_PAGES)) ? 1'b1 : used_rd;
  assign run_len = run_q;
  assign close_ok = cur_used && (run_q != '0) && ({1'b0, run_len} >= need_q) &&
                    (!found_q || run_len < best_len_q);
  assign used_ra = idx_q[PW-1:0];

  always_comb begin
    used_we = 1'b0;
    used_wa = ini_q[PW-1:0];
    used_wd = 1'b0;
    if (cmd_i.init_step) begin
      used_we = 1'b1;
    end else if (cmd_i.mark_step && k_q != need_q[NW-1:0] &&
                 (NW+1)'(best_start_q) + (NW+1)'(k_q) < (NW+1)'(bfpa_pkg::HEAP_PAGES)) begin
      used_we = 1'b1;
      used_wa = best_start_q + k_q[PW-1:0];
      used_wd = 1'b1;
    end else if (cmd_i.clear_step && k_q != cur_cnt_q &&
                 (NW+1)'(cur_start_q) + (NW+1)'(k_q) < (NW+1)'(bfpa_pkg::HEAP_PAGES)) begin
      used_we = 1'b1;
      used_wa = cur_start_q + k_q[PW-1:0];
    end
  end

  logic [31:0] tbl_addr;
  assign tbl_addr = heap_base_i + (32'(rd_start) << bfpa_pkg::PAGE_SHIFT);

  // shift: read of entry j lands while bidx is j+1, written back to j-1
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = count_q[BW-1:0];
    tbl_ws = best_start_q;
    tbl_wc = need_q[NW-1:0];
    tbl_ra = bidx_q[BW-1:0];
    if (cmd_i.shwr) begin
      tbl_we = 1'b1;
      tbl_wa = BW'(bidx_q - CW'(2));
      tbl_ws = rd_start;
      tbl_wc = rd_cnt;
    end else if (cmd_i.append) begin
      tbl_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ini_q <= '0;
    end else begin
      if (cmd_i.init_step) ini_q <= ini_q + NW'(1);
      if (cmd_i.append) count_q <= count_q + CW'(1);
      if (cmd_i.shrd && bidx_q >= count_q) count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_alloc) begin
      need_q <= (need_full > (33-bfpa_pkg::PAGE_SHIFT)'(bfpa_pkg::HEAP_PAGES)) ?
                (NW+1)'(bfpa_pkg::HEAP_PAGES + 1) : (NW+1)'(need_full);
      idx_q <= '0;
      run_q <= '0;
      found_q <= 1'b0;
      k_q <= '0;
    end
    if (cmd_i.start_free) begin
      addr_q <= addr_i;
      bidx_q <= '0;
    end
    if (cmd_i.scan_step) begin
      idx_q <= idx_q + NW'(1);
      if (proc) begin
        if (!cur_used) begin
          if (run_q == '0) run_start_q <= pos[PW-1:0];
          run_q <= run_q + NW'(1);
        end else begin
          run_q <= '0;
          if (close_ok) begin
            found_q <= 1'b1;
            best_start_q <= run_start_q;
            best_len_q <= run_len;
          end
        end
      end
    end
    if (cmd_i.mark_step) k_q <= k_q + NW'(1);
    if (cmd_i.frd && !sts_o.search_end) bidx_q <= bidx_q + CW'(1);
    if (cmd_i.fcmp) begin
      cur_start_q <= rd_start;
      cur_cnt_q <= rd_cnt;
      k_q <= '0;
    end
    if (cmd_i.clear_step) k_q <= k_q + NW'(1);
    if (cmd_i.shrd && !sts_o.shift_done) bidx_q <= bidx_q + CW'(1);
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_addr_q <= cmd_i.res_addr_ok ?
        heap_base_i + (32'(best_start_q) << bfpa_pkg::PAGE_SHIFT) : 32'd0;
    end
  end

  // frd: read issued for bidx; fcmp compares the registered data.
  logic hit_now;
  assign hit_now = (tbl_addr == addr_q);
  logic fcmp_pending;

  always_comb begin
    sts_o = '0;
    sts_o.init_done = (ini_q == NW'(bfpa_pkg::HEAP_PAGES));
    sts_o.scan_done = at_end;
    sts_o.found = found_q;
    sts_o.full = (count_q >= CW'(bfpa_pkg::MAX_BLOCKS));
    sts_o.mark_done = (k_q == need_q[NW-1:0]) || need_q[NW];
    sts_o.search_end = (bidx_q >= count_q) && !fcmp_pending;
    sts_o.hit = hit_now;
    sts_o.clear_done = (k_q == cur_cnt_q);
    sts_o.shift_done = (bidx_q >= count_q);
  end
  assign fcmp_pending = 1'b0;

  assign res_addr_o = res_addr_q;
  assign res_status_o = res_status_q;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(bfpa_pkg::MAX_BLOCKS)) else $error("block count overflow");
  a_app: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !sts_o.full) else $error("append into full table");
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.append && cmd_i.shwr)) else $error("table write conflict");
endmodule
